// File: rtl/sclp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sclp_pkg;

	// query codes
	localparam logic OP_CLOSEST   = 1'b0;
	localparam logic OP_LOOKAHEAD = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_START_X   = 3'd0;
	localparam logic [2:0] REG_START_Y   = 3'd1;
	localparam logic [2:0] REG_END_X     = 3'd2;
	localparam logic [2:0] REG_END_Y     = 3'd3;
	localparam logic [2:0] REG_TOLERANCE = 3'd4;

	localparam logic [30:0] TOL_RESET = 31'd3277;

	// datapath widths
	localparam int unsigned LEN_W   = 66;
	localparam int unsigned DIV_QW  = 64;
	localparam int unsigned DIV_NW  = DIV_QW + LEN_W;
	localparam int unsigned QUO_W   = 35;
	localparam int unsigned STEP_W  = 31;
	localparam int unsigned Y_QW    = 33;
	localparam int unsigned Y_DW    = 33;
	localparam int unsigned DIST_RW = 34;

	// request to result, in clock cycles
	localparam int unsigned SCLP_LATENCY = 177;

	typedef struct packed {
		logic               op;
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
		logic        [30:0] look_distance;
	} sclp_req_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic        [30:0] distance;
		logic               online;
	} sclp_resp_t;

	// request state carried through the first divider and the step root
	typedef struct packed {
		logic               op;
		logic               vert;
		logic               dx_neg;
		logic               dy_nonneg;
		logic               neg;
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
		logic        [30:0] look;
	} sclp_mid_t;

	typedef struct packed {
		sclp_mid_t        mid;
		logic [QUO_W-1:0] quo;
	} sclp_post_t;

	// carried through the y divider
	typedef struct packed {
		logic               vert;
		logic               neg;
		logic               online;
		logic signed [31:0] x;
		logic signed [31:0] yv;
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
	} sclp_ydiv_t;

	// carried through the distance root
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               online;
	} sclp_pt_t;

endpackage

`default_nettype wire

// File: rtl/sclp_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per stage, needs num < den * 2^QW
module sclp_div #(
	parameter int QW = 33,
	parameter int DW = 33,
	parameter int PW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [QW+DW-1:0] in_num,
	input  logic [DW-1:0]    in_den,
	input  logic [PW-1:0]    in_pay,
	output logic             out_valid,
	output logic [QW-1:0]    out_quo,
	output logic [PW-1:0]    out_pay
);

	logic          v_s   [QW];
	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] num_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [PW-1:0] pay_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          v_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] num_in;
		logic [QW-1:0] quo_in;
		logic [PW-1:0] pay_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = in_num[QW+DW-1:QW];
			assign num_in = in_num[QW-1:0];
			assign quo_in = '0;
			assign den_in = in_den;
			assign pay_in = in_pay;
		end else begin : g_next
			assign v_in   = v_s[k-1];
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
			assign pay_in = pay_s[k-1];
		end

		assign trial = {rem_in, num_in[QW-1]};
		assign ge    = trial >= {1'b0, den_in};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_s[k] <= {num_in[QW-2:0], 1'b0};
			quo_s[k] <= {quo_in[QW-2:0], ge};
			den_s[k] <= den_in;
			pay_s[k] <= pay_in;
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_pay   = pay_s[QW-1];

endmodule

`default_nettype wire

// File: rtl/sclp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// floor square root, one root bit per stage
module sclp_sqrt #(
	parameter int RW = 31,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [2*RW-1:0] in_rad,
	input  logic [PW-1:0]   in_pay,
	output logic            out_valid,
	output logic [RW-1:0]   out_root,
	output logic [PW-1:0]   out_pay
);

	logic            v_s    [RW];
	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] rad_s  [RW];
	logic [PW-1:0]   pay_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic            v_in;
		logic [RW+1:0]   rem_in;
		logic [RW-1:0]   root_in;
		logic [2*RW-1:0] rad_in;
		logic [PW-1:0]   pay_in;
		logic [RW+3:0]   shifted;
		logic [RW+3:0]   trial;
		logic [RW+3:0]   diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = in_rad;
			assign pay_in  = in_pay;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign pay_in  = pay_s[k-1];
		end

		assign shifted = {rem_in, rad_in[2*RW-1:2*RW-2]};
		assign trial   = {2'b00, root_in, 2'b01};
		assign ge      = shifted >= trial;
		assign diff    = shifted - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
			root_s[k] <= {root_in[RW-2:0], ge};
			rad_s[k]  <= {rad_in[2*RW-3:0], 2'b00};
			pay_s[k]  <= pay_in;
		end
	end

	assign out_valid = v_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_pay   = pay_s[RW-1];

endmodule

`default_nettype wire

// File: rtl/sclp_front.sv
`timescale 1ns / 1ps
`default_nettype none

// segment deltas, products and the numerator / denominator of the first division
module sclp_front import sclp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sclp_req_t          in_req,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	output logic               out_valid,
	output logic [DIV_NW-1:0]  out_num,
	output logic [LEN_W-1:0]   out_den,
	output sclp_mid_t          out_mid
);

	// stage 1: differences
	logic               v_s1;
	sclp_req_t          req_s1;
	logic signed [32:0] dx_s1, dy_s1, ox_s1, oy_s1;

	// stage 2: products
	logic               v_s2;
	sclp_mid_t          mid_s2;
	logic signed [65:0] dxx_s2, dyy_s2, dox_s2, doy_s2;
	logic [62:0]        p_s2;
	logic [32:0]        adx_s2;

	// stage 3: sums
	logic               v_s3;
	sclp_mid_t          mid_s3;
	logic [LEN_W-1:0]   len2_s3;
	logic signed [66:0] dot_s3;
	logic [62:0]        p_s3;
	logic [32:0]        adx_s3;

	// stage 4: partial products of the numerator
	logic               v_s4;
	sclp_mid_t          mid_s4;
	logic [LEN_W-1:0]   len2_s4;
	logic [63:0]        pp_ll_s4;
	logic [66:0]        pp_lh_s4, pp_hl_s4;
	logic [69:0]        pp_hh_s4;

	// stage 5: numerator
	logic               v_s5;
	sclp_mid_t          mid_s5;
	logic [LEN_W-1:0]   len2_s5;
	logic [DIV_NW-1:0]  num_s5;

	logic [32:0] adx_w;
	logic [63:0] p_full;
	logic [66:0] dot_mag, a_op, b_op;
	sclp_mid_t   mid_sign_w;

	assign adx_w   = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
	assign p_full  = req_s1.look_distance * adx_w;
	assign dot_mag = dot_s3[66] ? 67'(-dot_s3) : 67'(dot_s3);
	assign a_op    = (mid_s3.op == OP_LOOKAHEAD) ? {4'b0, p_s3} : dot_mag;
	assign b_op    = (mid_s3.op == OP_LOOKAHEAD) ? {4'b0, p_s3} : {34'b0, adx_s3};

	// quotient sign of the closest point projection
	always_comb begin
		mid_sign_w     = mid_s3;
		mid_sign_w.neg = (mid_s3.op == OP_CLOSEST) && (dot_s3[66] ^ mid_s3.dx_neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= in_req;
		dx_s1  <= {end_x[31], end_x} - {start_x[31], start_x};
		dy_s1  <= {end_y[31], end_y} - {start_y[31], start_y};
		ox_s1  <= {in_req.cur_x[31], in_req.cur_x} - {start_x[31], start_x};
		oy_s1  <= {in_req.cur_y[31], in_req.cur_y} - {start_y[31], start_y};

		dxx_s2           <= dx_s1 * dx_s1;
		dyy_s2           <= dy_s1 * dy_s1;
		dox_s2           <= dx_s1 * ox_s1;
		doy_s2           <= dy_s1 * oy_s1;
		p_s2             <= p_full[62:0];
		adx_s2           <= adx_w;
		mid_s2.op        <= req_s1.op;
		mid_s2.vert      <= (dx_s1 == '0);
		mid_s2.dx_neg    <= dx_s1[32];
		mid_s2.dy_nonneg <= !dy_s1[32];
		mid_s2.neg       <= 1'b0;
		mid_s2.cur_x     <= req_s1.cur_x;
		mid_s2.cur_y     <= req_s1.cur_y;
		mid_s2.look      <= req_s1.look_distance;

		mid_s3  <= mid_s2;
		len2_s3 <= dxx_s2 + dyy_s2;
		dot_s3  <= {dox_s2[65], dox_s2} + {doy_s2[65], doy_s2};
		p_s3    <= p_s2;
		adx_s3  <= adx_s2;

		mid_s4   <= mid_sign_w;
		len2_s4  <= len2_s3;
		pp_ll_s4 <= a_op[31:0] * b_op[31:0];
		pp_lh_s4 <= a_op[31:0] * b_op[66:32];
		pp_hl_s4 <= a_op[66:32] * b_op[31:0];
		pp_hh_s4 <= a_op[66:32] * b_op[66:32];

		mid_s5  <= mid_s4;
		len2_s5 <= len2_s4;
		num_s5  <= DIV_NW'(pp_ll_s4) + (DIV_NW'(pp_lh_s4) << 32)
			+ (DIV_NW'(pp_hl_s4) << 32) + (DIV_NW'(pp_hh_s4) << 64);
	end

	assign out_valid = v_s5;
	assign out_num   = num_s5;
	assign out_den   = len2_s5;
	assign out_mid   = mid_s5;

endmodule

`default_nettype wire

// File: rtl/sclp_back.sv
`timescale 1ns / 1ps
`default_nettype none

// target, clamp, y on the segment and distance to the current point
module sclp_back import sclp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sclp_post_t         in_post,
	input  logic [STEP_W-1:0]  in_root,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic [30:0]        tolerance,
	output logic               out_valid,
	output sclp_resp_t         out_resp
);

	sclp_mid_t mid_w;
	assign mid_w = in_post.mid;

	// stage 1: unclamped target and clamp span
	logic               v_s1;
	sclp_mid_t          mid_s1;
	logic signed [35:0] t_s1;
	logic signed [31:0] lo_s1, hi_s1;

	// stage 2: clamp
	logic               v_s2;
	sclp_mid_t          mid_s2;
	logic signed [35:0] t_s2;
	logic signed [31:0] cl_s2;

	// stage 3: clamp shift, x
	logic               v_s3;
	sclp_mid_t          mid_s3;
	logic signed [35:0] sh_s3;
	logic signed [31:0] x_s3, yv_s3;
	logic signed [32:0] xm_s3;

	// stage 4: online flag, dy * (x - start_x)
	logic               v_s4;
	sclp_mid_t          mid_s4;
	logic               online_s4;
	logic signed [31:0] x_s4, yv_s4;
	logic signed [65:0] prod_s4;

	// stage 5: magnitudes for the y divider
	logic               v_s5;
	sclp_ydiv_t         yd_s5;
	logic [65:0]        num_s5;
	logic [32:0]        den_s5;

	// stages 6 to 9: y, deltas, squares, sum
	logic               v_s6, v_s7, v_s8, v_s9;
	sclp_pt_t           pt_s6, pt_s7, pt_s8, pt_s9;
	logic signed [31:0] cx_s6, cy_s6;
	logic signed [32:0] ex_s7, ey_s7;
	logic signed [65:0] exx_s8, eyy_s8;
	logic [2*DIST_RW-1:0] sum_s9;

	// stage 10: result
	logic               v_s10;
	sclp_resp_t         resp_s10;

	logic signed [35:0] ax_w, cx_w, cy_w, quo_w, root_w, look_w, t_w;
	logic signed [35:0] lo_w, hi_w;
	logic signed [31:0] span_a, span_b, x_w;
	logic [35:0]        sh_mag;
	logic signed [32:0] dx_w, dy_w;
	logic [32:0]        adx_w;
	logic [65:0]        prod_mag;

	logic               yd_valid;
	logic [Y_QW-1:0]    yd_quo;
	logic [$bits(sclp_ydiv_t)-1:0] yd_pay;
	sclp_ydiv_t         yd_out;
	logic signed [33:0] yq_w, ysum_w;
	logic signed [31:0] y_w;

	logic               sq_valid;
	logic [DIST_RW-1:0] sq_root;
	logic [$bits(sclp_pt_t)-1:0] sq_pay;
	sclp_pt_t           sq_pt;

	assign ax_w   = {{4{start_x[31]}}, start_x};
	assign cx_w   = {{4{mid_w.cur_x[31]}}, mid_w.cur_x};
	assign cy_w   = {{4{mid_w.cur_y[31]}}, mid_w.cur_y};
	assign quo_w  = {1'b0, in_post.quo};
	assign root_w = {5'b0, in_root};
	assign look_w = {5'b0, mid_w.look};

	always_comb begin
		if (!mid_w.vert) begin
			if (mid_w.op == OP_CLOSEST) begin
				t_w = mid_w.neg ? ax_w - quo_w : ax_w + quo_w;
			end else begin
				t_w = mid_w.dx_neg ? cx_w - root_w : cx_w + root_w;
			end
		end else if (mid_w.op == OP_CLOSEST) begin
			t_w = cy_w;
		end else begin
			t_w = mid_w.dy_nonneg ? cy_w + look_w : cy_w - look_w;
		end
	end

	assign span_a = mid_w.vert ? start_y : start_x;
	assign span_b = mid_w.vert ? end_y : end_x;

	assign lo_w   = {{4{lo_s1[31]}}, lo_s1};
	assign hi_w   = {{4{hi_s1[31]}}, hi_s1};
	assign x_w    = mid_s2.vert ? start_x : cl_s2;
	assign sh_mag = sh_s3[35] ? 36'(-sh_s3) : 36'(sh_s3);
	assign dx_w   = {end_x[31], end_x} - {start_x[31], start_x};
	assign dy_w   = {end_y[31], end_y} - {start_y[31], start_y};
	assign adx_w  = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
	assign prod_mag = prod_s4[65] ? 66'(-prod_s4) : 66'(prod_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= yd_valid;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		mid_s1 <= mid_w;
		t_s1   <= t_w;
		lo_s1  <= (span_a < span_b) ? span_a : span_b;
		hi_s1  <= (span_a < span_b) ? span_b : span_a;

		mid_s2 <= mid_s1;
		t_s2   <= t_s1;
		if (t_s1 < lo_w) begin
			cl_s2 <= lo_s1;
		end else if (t_s1 > hi_w) begin
			cl_s2 <= hi_s1;
		end else begin
			cl_s2 <= t_s1[31:0];
		end

		mid_s3 <= mid_s2;
		sh_s3  <= t_s2 - {{4{cl_s2[31]}}, cl_s2};
		x_s3   <= x_w;
		yv_s3  <= cl_s2;
		xm_s3  <= {x_w[31], x_w} - {start_x[31], start_x};

		mid_s4    <= mid_s3;
		online_s4 <= !((mid_s3.op == OP_LOOKAHEAD) && (sh_mag > {5'b0, tolerance}));
		x_s4      <= x_s3;
		yv_s4     <= yv_s3;
		prod_s4   <= dy_w * xm_s3;

		num_s5        <= prod_mag;
		den_s5        <= adx_w;
		yd_s5.vert    <= mid_s4.vert;
		yd_s5.neg     <= prod_s4[65] ^ mid_s4.dx_neg;
		yd_s5.online  <= online_s4;
		yd_s5.x       <= x_s4;
		yd_s5.yv      <= yv_s4;
		yd_s5.cur_x   <= mid_s4.cur_x;
		yd_s5.cur_y   <= mid_s4.cur_y;

		pt_s6.x      <= yd_out.x;
		pt_s6.y      <= y_w;
		pt_s6.online <= yd_out.online;
		cx_s6        <= yd_out.cur_x;
		cy_s6        <= yd_out.cur_y;

		pt_s7 <= pt_s6;
		ex_s7 <= {cx_s6[31], cx_s6} - {pt_s6.x[31], pt_s6.x};
		ey_s7 <= {cy_s6[31], cy_s6} - {pt_s6.y[31], pt_s6.y};

		pt_s8  <= pt_s7;
		exx_s8 <= ex_s7 * ex_s7;
		eyy_s8 <= ey_s7 * ey_s7;

		pt_s9  <= pt_s8;
		sum_s9 <= {2'b00, exx_s8} + {2'b00, eyy_s8};

		resp_s10.point_x  <= sq_pt.x;
		resp_s10.point_y  <= sq_pt.y;
		resp_s10.online   <= sq_pt.online;
		// saturate to the 31 bit field
		resp_s10.distance <= (|sq_root[DIST_RW-1:31]) ? '1 : sq_root[30:0];
	end

	sclp_div #(
		.QW (Y_QW),
		.DW (Y_DW),
		.PW ($bits(sclp_ydiv_t))
	) u_ydiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_num    (num_s5),
		.in_den    (den_s5),
		.in_pay    (yd_s5),
		.out_valid (yd_valid),
		.out_quo   (yd_quo),
		.out_pay   (yd_pay)
	);

	assign yd_out = yd_pay;
	assign yq_w   = yd_out.neg ? -{1'b0, yd_quo} : {1'b0, yd_quo};
	assign ysum_w = {{2{start_y[31]}}, start_y} + yq_w;
	assign y_w    = yd_out.vert ? yd_out.yv : ysum_w[31:0];

	sclp_sqrt #(
		.RW (DIST_RW),
		.PW ($bits(sclp_pt_t))
	) u_dist_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.in_rad    (sum_s9),
		.in_pay    (pt_s9),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_pay   (sq_pay)
	);

	assign sq_pt = sq_pay;

	assign out_valid = v_s10;
	assign out_resp  = resp_s10;

endmodule

`default_nettype wire

// File: rtl/segment_closest_and_lookahead_point.sv
// Closest point and look-ahead point on a line segment, signed Q16.16. The
// segment ends and the on-line tolerance are written through the cfg port,
// which is always ready; write them only while no request is in flight. A
// request is taken on every clock edge where start is high (busy stays low),
// so one request per cycle is sustained. Each request gives exactly one
// result, shown on result for the single cycle in which done is high;
// results come out in request order and there is no way to hold them off,
// so the receiver must capture them as they appear. The latency is set by
// the bit-serial pipelines: a 64-stage divider for the projection / step
// ratio, a 31-stage root for the step, a 33-stage divider for y and a
// 34-stage root for the distance, plus fifteen stages of multiply, add and
// clamp around them.
`timescale 1ns / 1ps
`default_nettype none

module segment_closest_and_lookahead_point import sclp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        start,
	output logic        busy,
	input  sclp_req_t   req,
	// result side
	output logic        done,
	output sclp_resp_t  result,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// segment and tolerance registers
	logic signed [31:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic [30:0]        tol_q;

	// first division: len2 = dx^2 + dy^2 as divisor
	logic               fr_valid;
	logic [DIV_NW-1:0]  fr_num;
	logic [LEN_W-1:0]   fr_den;
	sclp_mid_t          fr_mid;

	logic               dv_valid;
	logic [DIV_QW-1:0]  dv_quo;
	logic [$bits(sclp_mid_t)-1:0] dv_pay;
	sclp_post_t         dv_post;

	// step root
	logic               rt_valid;
	logic [STEP_W-1:0]  rt_root;
	logic [$bits(sclp_post_t)-1:0] rt_pay;

	// pipeline never stalls: a request every cycle is fine
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
			tol_q     <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_X:   start_x_q <= cfg_data;
				REG_START_Y:   start_y_q <= cfg_data;
				REG_END_X:     end_x_q   <= cfg_data;
				REG_END_Y:     end_y_q   <= cfg_data;
				REG_TOLERANCE: tol_q     <= cfg_data[30:0];
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// deltas, dot product, look * |dx| and the wide numerator
	sclp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_req    (req),
		.start_x   (start_x_q),
		.start_y   (start_y_q),
		.end_x     (end_x_q),
		.end_y     (end_y_q),
		.out_valid (fr_valid),
		.out_num   (fr_num),
		.out_den   (fr_den),
		.out_mid   (fr_mid)
	);

	// op 0: |dot * dx| / len2, op 1: (look * dx)^2 / len2
	sclp_div #(
		.QW (DIV_QW),
		.DW (LEN_W),
		.PW ($bits(sclp_mid_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_num    (fr_num),
		.in_den    (fr_den),
		.in_pay    (fr_mid),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_pay   (dv_pay)
	);

	assign dv_post.mid = dv_pay;
	assign dv_post.quo = dv_quo[QUO_W-1:0];

	// look-ahead step along x; the op 0 quotient rides along as payload
	sclp_sqrt #(
		.RW (STEP_W),
		.PW ($bits(sclp_post_t))
	) u_step_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_rad    (dv_quo[2*STEP_W-1:0]),
		.in_pay    (dv_post),
		.out_valid (rt_valid),
		.out_root  (rt_root),
		.out_pay   (rt_pay)
	);

	// clamp, online test, y and distance
	sclp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_valid),
		.in_post   (rt_pay),
		.in_root   (rt_root),
		.start_x   (start_x_q),
		.start_y   (start_y_q),
		.end_x     (end_x_q),
		.end_y     (end_y_q),
		.tolerance (tol_q),
		.out_valid (done),
		.out_resp  (result)
	);

endmodule

`default_nettype wire

// File: rtl/sclp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sclp_checker import sclp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input sclp_req_t  req,
	input logic       done,
	input sclp_resp_t result,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// every request gives its result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##SCLP_LATENCY done)
		else $error("request without result");

	// no result without a request
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, SCLP_LATENCY))
		else $error("result without request");

	// closest point queries always land on the segment
	a_closest_online: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(req.op, SCLP_LATENCY) == OP_CLOSEST) |-> result.online)
		else $error("closest point flagged off line");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind segment_closest_and_lookahead_point sclp_checker u_sclp_checker (.*);

`default_nettype wire
